FILE: rtl/core/pcs_pkg.sv
// pyro channel sequencer package: word types, register map, reset values
// and the continuity classifier used by the step logic
// no dependencies
package pcs_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned ADC_W  = 12;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // request types
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_FIRE = 1'b1;

    // channel codes
    localparam logic [1:0] CH_NONE = 2'd0;
    localparam logic [1:0] CH_ONE  = 2'd1;
    localparam logic [1:0] CH_TWO  = 2'd2;

    // continuity codes
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SETTLE_TIME     = 3'd0;
    localparam logic [2:0] REG_IDLE_TIME       = 3'd1;
    localparam logic [2:0] REG_FIRE_TIME       = 3'd2;
    localparam logic [2:0] REG_OPEN_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_SHORT_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_OWNS_CH1        = 3'd5;
    localparam logic [2:0] REG_OWNS_CH2        = 3'd6;

    localparam logic [DUR_W-1:0] RST_SETTLE_TIME     = 16'd10;
    localparam logic [DUR_W-1:0] RST_IDLE_TIME       = 16'd990;
    localparam logic [DUR_W-1:0] RST_FIRE_TIME       = 16'd500;
    localparam logic [ADC_W-1:0] RST_OPEN_THRESHOLD  = 12'd3800;
    localparam logic [ADC_W-1:0] RST_SHORT_THRESHOLD = 12'd50;

    typedef struct packed {
        logic [DUR_W-1:0] settle_time;
        logic [DUR_W-1:0] idle_time;
        logic [DUR_W-1:0] fire_time;
        logic [ADC_W-1:0] open_threshold;
        logic [ADC_W-1:0] short_threshold;
        logic             owns_ch1;
        logic             owns_ch2;
    } cfg_t;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        channel;
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  adc_ch1;
        logic [ADC_W-1:0]  adc_ch2;
    } cmd_word_t;

    typedef struct packed {
        logic             common_enable;
        logic             fire_enable_ch1;
        logic             fire_enable_ch2;
        logic             firing;
        logic             reading_valid;
        logic [ADC_W-1:0] raw_ch1;
        logic [1:0]       status_ch1;
        logic [ADC_W-1:0] raw_ch2;
        logic [1:0]       status_ch2;
    } report_word_t;

    // open wins when the thresholds cross
    function automatic logic [1:0] status_of(
        input logic [ADC_W-1:0] raw,
        input logic [ADC_W-1:0] open_th,
        input logic [ADC_W-1:0] short_th
    );
        logic [1:0] st;
        if (raw > open_th)
        begin
            st = ST_OPEN;
        end
        else if (raw < short_th)
        begin
            st = ST_SHORT;
        end
        else
        begin
            st = ST_GOOD;
        end
        return st;
    endfunction

endpackage

FILE: rtl/core/pcs_cmd_if.sv
// command channel: update ticks and fire requests
// depends on pcs_pkg
interface pcs_cmd_if;
    logic                  valid;
    logic                  ready;
    pcs_pkg::cmd_word_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pcs_report_if.sv
// report channel: pad levels and continuity reading
// depends on pcs_pkg
interface pcs_report_if;
    logic                  valid;
    logic                  ready;
    pcs_pkg::report_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pcs_cfg.sv
// configuration registers behind the apb-style port
// depends on pcs_pkg
module pcs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcs_pkg::DATA_W-1:0]    pwdata,
    output logic [pcs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output pcs_pkg::cfg_t                 cfg
);

    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cfg_t cfg_next;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite & pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                pcs_pkg::REG_SETTLE_TIME:     cfg_next.settle_time     = pwdata[15:0];
                pcs_pkg::REG_IDLE_TIME:       cfg_next.idle_time       = pwdata[15:0];
                pcs_pkg::REG_FIRE_TIME:       cfg_next.fire_time       = pwdata[15:0];
                pcs_pkg::REG_OPEN_THRESHOLD:  cfg_next.open_threshold  = pwdata[11:0];
                pcs_pkg::REG_SHORT_THRESHOLD: cfg_next.short_threshold = pwdata[11:0];
                pcs_pkg::REG_OWNS_CH1:        cfg_next.owns_ch1        = pwdata[0];
                pcs_pkg::REG_OWNS_CH2:        cfg_next.owns_ch2        = pwdata[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            pcs_pkg::REG_SETTLE_TIME:     prdata = {16'h0, cfg_reg.settle_time};
            pcs_pkg::REG_IDLE_TIME:       prdata = {16'h0, cfg_reg.idle_time};
            pcs_pkg::REG_FIRE_TIME:       prdata = {16'h0, cfg_reg.fire_time};
            pcs_pkg::REG_OPEN_THRESHOLD:  prdata = {20'h0, cfg_reg.open_threshold};
            pcs_pkg::REG_SHORT_THRESHOLD: prdata = {20'h0, cfg_reg.short_threshold};
            pcs_pkg::REG_OWNS_CH1:        prdata = {31'h0, cfg_reg.owns_ch1};
            pcs_pkg::REG_OWNS_CH2:        prdata = {31'h0, cfg_reg.owns_ch2};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_time     <= pcs_pkg::RST_SETTLE_TIME;
            cfg_reg.idle_time       <= pcs_pkg::RST_IDLE_TIME;
            cfg_reg.fire_time       <= pcs_pkg::RST_FIRE_TIME;
            cfg_reg.open_threshold  <= pcs_pkg::RST_OPEN_THRESHOLD;
            cfg_reg.short_threshold <= pcs_pkg::RST_SHORT_THRESHOLD;
            cfg_reg.owns_ch1        <= 1'b1;
            cfg_reg.owns_ch2        <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/pcs_step.sv
// sequencer state and the single-pass update for one command word
// depends on pcs_pkg
module pcs_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  pcs_pkg::cmd_word_t    cmd,
    input  pcs_pkg::cfg_t         cfg,
    output pcs_pkg::report_word_t result
);

    localparam int unsigned PAD_COM = 0;
    localparam int unsigned PAD_CH1 = 1;
    localparam int unsigned PAD_CH2 = 2;

    logic [1:0]                      active_reg, active_next;
    logic [pcs_pkg::TIME_W-1:0]      pulse_start_reg, pulse_start_next;
    logic                            phase_reg, phase_next;
    logic [pcs_pkg::TIME_W-1:0]      deadline_reg, deadline_next;
    logic                            have_reg, have_next;
    logic [pcs_pkg::ADC_W-1:0]       sample1_reg, sample1_next;
    logic [pcs_pkg::ADC_W-1:0]       sample2_reg, sample2_next;
    logic [2:0]                      pad_reg, pad_next;

    logic [pcs_pkg::TIME_W-1:0]      elapsed;
    logic [pcs_pkg::TIME_W-1:0]      to_deadline;
    logic                            start_sense;

    assign elapsed     = cmd.now_ms - pulse_start_reg;
    assign to_deadline = cmd.now_ms - deadline_reg;

    always_comb
    begin
        active_next      = active_reg;
        pulse_start_next = pulse_start_reg;
        phase_next       = phase_reg;
        deadline_next    = deadline_reg;
        have_next        = have_reg;
        sample1_next     = sample1_reg;
        sample2_next     = sample2_reg;
        pad_next         = pad_reg;
        start_sense      = 1'b0;

        priority if (cmd.req_type == pcs_pkg::REQ_FIRE)
        begin
            // channel codes other than one and two are dropped
            if (cmd.channel == pcs_pkg::CH_ONE || cmd.channel == pcs_pkg::CH_TWO)
            begin
                pad_next[PAD_COM] = 1'b1;
                if (cmd.channel == pcs_pkg::CH_ONE)
                begin
                    pad_next[PAD_CH1] = 1'b1;
                end
                else
                begin
                    pad_next[PAD_CH2] = 1'b1;
                end
                active_next      = cmd.channel;
                pulse_start_next = cmd.now_ms;
            end
        end
        else if (active_reg != pcs_pkg::CH_NONE)
        begin
            if (elapsed >= {16'h0, cfg.fire_time})
            begin
                if (active_reg == pcs_pkg::CH_ONE)
                begin
                    pad_next[PAD_CH1] = 1'b0;
                end
                else
                begin
                    pad_next[PAD_CH2] = 1'b0;
                end
                active_next = pcs_pkg::CH_NONE;
                start_sense = 1'b1;
            end
        end
        else if (!to_deadline[pcs_pkg::TIME_W-1])
        begin
            if (!phase_reg)
            begin
                start_sense = 1'b1;
            end
            else
            begin
                sample1_next      = cmd.adc_ch1;
                sample2_next      = cmd.adc_ch2;
                pad_next[PAD_COM] = 1'b0;
                have_next         = 1'b1;
                phase_next        = 1'b0;
                deadline_next     = cmd.now_ms + {16'h0, cfg.idle_time};
            end
        end
        else
        begin
            // deadline not reached yet, state holds
        end

        // released channels keep their level
        if (start_sense)
        begin
            if (cfg.owns_ch1)
            begin
                pad_next[PAD_CH1] = 1'b0;
            end
            if (cfg.owns_ch2)
            begin
                pad_next[PAD_CH2] = 1'b0;
            end
            pad_next[PAD_COM] = 1'b1;
            phase_next        = 1'b1;
            deadline_next     = cmd.now_ms + {16'h0, cfg.settle_time};
        end
    end

    always_comb
    begin
        result.common_enable   = pad_next[PAD_COM];
        result.fire_enable_ch1 = pad_next[PAD_CH1];
        result.fire_enable_ch2 = pad_next[PAD_CH2];
        result.firing          = (active_next != pcs_pkg::CH_NONE);
        result.reading_valid   = have_next;
        if (have_next)
        begin
            result.raw_ch1    = sample1_next;
            result.status_ch1 = pcs_pkg::status_of(sample1_next, cfg.open_threshold,
                                                   cfg.short_threshold);
            result.raw_ch2    = sample2_next;
            result.status_ch2 = pcs_pkg::status_of(sample2_next, cfg.open_threshold,
                                                   cfg.short_threshold);
        end
        else
        begin
            result.raw_ch1    = '0;
            result.status_ch1 = pcs_pkg::ST_OPEN;
            result.raw_ch2    = '0;
            result.status_ch2 = pcs_pkg::ST_OPEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= pcs_pkg::CH_NONE;
            pulse_start_reg <= '0;
            phase_reg       <= 1'b0;
            deadline_reg    <= '0;
            have_reg        <= 1'b0;
            sample1_reg     <= '0;
            sample2_reg     <= '0;
            pad_reg         <= '0;
        end
        else if (accept)
        begin
            active_reg      <= active_next;
            pulse_start_reg <= pulse_start_next;
            phase_reg       <= phase_next;
            deadline_reg    <= deadline_next;
            have_reg        <= have_next;
            sample1_reg     <= sample1_next;
            sample2_reg     <= sample2_next;
            pad_reg         <= pad_next;
        end
    end

    // a running pulse always holds the common enable
    a_fire_holds_common: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg != pcs_pkg::CH_NONE |-> pad_reg[PAD_COM])
        else $error("pulse running without common enable");

    // settling always holds the common enable
    a_settle_holds_common: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> pad_reg[PAD_COM])
        else $error("settle phase without common enable");

    // a completed reading is never withdrawn
    a_reading_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |=> have_reg)
        else $error("reading valid dropped");

    // samples stay clear until the first reading lands
    a_samples_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !have_reg |-> (sample1_reg == '0 && sample2_reg == '0))
        else $error("sample latched without a reading");

endmodule

FILE: rtl/core/pyro_channel_sequencer_unit.sv
// top level of the two-channel igniter sequencer: config port, step logic
// and the report output register
// depends on pcs_pkg, pcs_cmd_if, pcs_report_if, pcs_cfg, pcs_step
//
//  port     dir  protocol     word
//  cmd      in   valid/ready  tick or fire request with time and adc samples
//  report   out  valid/ready  pad levels, firing, latest continuity reading
//  apb      in   setup/access configuration registers at 4 * index
//
// one word per cycle while cmd.ready is high; a report is registered in the cycle after its command word
// the step logic is a single compare/add pass into the report register
// cmd.ready stays high while the report register is empty or being drained
// reset clears the sequencer state and loads the default register values
module pyro_channel_sequencer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    pcs_cmd_if.sink                    cmd,
    pcs_report_if.source               report,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pcs_pkg::DATA_W-1:0] pwdata,
    output logic [pcs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    pcs_pkg::cfg_t         cfg;
    pcs_pkg::report_word_t result;
    pcs_pkg::report_word_t report_reg;
    logic                  report_valid_reg, report_valid_next;
    logic                  accept;

    assign cmd.ready      = !report_valid_reg || report.ready;
    assign accept         = cmd.valid && cmd.ready;
    assign report.valid   = report_valid_reg;
    assign report.payload = report_reg;

    pcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcs_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd.payload),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        priority if (accept)
        begin
            report_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            report_valid_next = 1'b0;
        end
        else
        begin
            report_valid_next = report_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else
        begin
            report_valid_reg <= report_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            report_reg <= result;
        end
    end

    // every accepted command yields a report in the next cycle
    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> report_valid_reg)
        else $error("accepted command without report");

    // a waiting report is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid_reg && !report.ready) |-> !accept)
        else $error("report overwritten while stalled");

endmodule

FILE: test/pcs_report_checker.sv
`timescale 1ns / 1ps
// sequencer report checker: follows register writes, predicts the report word of each
// accepted command word and compares it field by field with the reports
// depends on pcs_pkg
module pcs_report_checker
    import pcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  cmd_word_t         cmd_word,
    input  logic              rep_valid,
    input  logic              rep_ready,
    input  report_word_t      rep_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                pending,
    output int                errors
);

    // register copies
    logic [DUR_W-1:0] settle_len;
    logic [DUR_W-1:0] idle_ms;
    logic [DUR_W-1:0] pulse_ms;
    logic [ADC_W-1:0] open_lim;
    logic [ADC_W-1:0] short_lim;
    logic             own1;
    logic             own2;

    // sequencer state
    logic [1:0]        live_ch;
    logic [TIME_W-1:0] pulse_t0;
    logic              settling;
    logic [TIME_W-1:0] due_t;
    logic              have_rd;
    logic [ADC_W-1:0]  held1;
    logic [ADC_W-1:0]  held2;
    logic              pad_com;
    logic              pad1;
    logic              pad2;

    report_word_t reports_due[$];
    report_word_t want;
    report_word_t fresh;
    int           fails = 0;
    int           waiting = 0;
    int           seen = 0;

    assign errors  = fails;
    assign pending = waiting;

    function automatic logic [1:0] classify(input logic [ADC_W-1:0] raw);
        logic [1:0] st;
        if (raw > open_lim)
        begin
            st = ST_OPEN;
        end
        else if (raw < short_lim)
        begin
            st = ST_SHORT;
        end
        else
        begin
            st = ST_GOOD;
        end
        return st;
    endfunction

    task automatic start_sensing(input logic [TIME_W-1:0] now);
        if (own1)
        begin
            pad1 = 1'b0;
        end
        if (own2)
        begin
            pad2 = 1'b0;
        end
        pad_com  = 1'b1;
        settling = 1'b1;
        due_t    = now + {16'b0, settle_len};
    endtask

    task automatic advance(input cmd_word_t c, output report_word_t r);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] slack;
        elapsed = c.now_ms - pulse_t0;
        slack   = c.now_ms - due_t;
        if (c.req_type == REQ_FIRE)
        begin
            if (c.channel == CH_ONE || c.channel == CH_TWO)
            begin
                pad_com = 1'b1;
                if (c.channel == CH_ONE)
                begin
                    pad1 = 1'b1;
                end
                else
                begin
                    pad2 = 1'b1;
                end
                live_ch  = c.channel;
                pulse_t0 = c.now_ms;
            end
        end
        else if (live_ch != CH_NONE)
        begin
            if (elapsed >= {16'b0, pulse_ms})
            begin
                if (live_ch == CH_ONE)
                begin
                    pad1 = 1'b0;
                end
                else
                begin
                    pad2 = 1'b0;
                end
                live_ch = CH_NONE;
                start_sensing(c.now_ms);
            end
        end
        // deadline is due when the wrapped difference is not negative
        else if (!slack[TIME_W-1])
        begin
            if (!settling)
            begin
                start_sensing(c.now_ms);
            end
            else
            begin
                held1    = c.adc_ch1;
                held2    = c.adc_ch2;
                pad_com  = 1'b0;
                have_rd  = 1'b1;
                settling = 1'b0;
                due_t    = c.now_ms + {16'b0, idle_ms};
            end
        end
        r.common_enable   = pad_com;
        r.fire_enable_ch1 = pad1;
        r.fire_enable_ch2 = pad2;
        r.firing          = (live_ch != CH_NONE);
        r.reading_valid   = have_rd;
        r.raw_ch1         = have_rd ? held1 : '0;
        r.status_ch1      = have_rd ? classify(held1) : ST_OPEN;
        r.raw_ch2         = have_rd ? held2 : '0;
        r.status_ch2      = have_rd ? classify(held2) : ST_OPEN;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            if (fails < 10)
            begin
                $display("report %0d field %s: expected %0h, actual %0h",
                         seen, name, exp_v, act_v);
            end
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_len = RST_SETTLE_TIME;
            idle_ms   = RST_IDLE_TIME;
            pulse_ms  = RST_FIRE_TIME;
            open_lim  = RST_OPEN_THRESHOLD;
            short_lim = RST_SHORT_THRESHOLD;
            own1      = 1'b1;
            own2      = 1'b1;
            live_ch   = CH_NONE;
            pulse_t0  = '0;
            settling  = 1'b0;
            due_t     = '0;
            have_rd   = 1'b0;
            held1     = '0;
            held2     = '0;
            pad_com   = 1'b0;
            pad1      = 1'b0;
            pad2      = 1'b0;
            reports_due.delete();
            waiting <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SETTLE_TIME:     settle_len = pwdata[DUR_W-1:0];
                    REG_IDLE_TIME:       idle_ms   = pwdata[DUR_W-1:0];
                    REG_FIRE_TIME:       pulse_ms  = pwdata[DUR_W-1:0];
                    REG_OPEN_THRESHOLD:  open_lim  = pwdata[ADC_W-1:0];
                    REG_SHORT_THRESHOLD: short_lim = pwdata[ADC_W-1:0];
                    REG_OWNS_CH1:        own1      = pwdata[0];
                    REG_OWNS_CH2:        own2      = pwdata[0];
                    default: ;
                endcase
            end
            if (rep_valid && rep_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("report %0d arrived with no command word waiting: %0h",
                                 seen, rep_word);
                    end
                    fails++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("common_enable", 32'(want.common_enable),
                                32'(rep_word.common_enable));
                    check_field("fire_enable_ch1", 32'(want.fire_enable_ch1),
                                32'(rep_word.fire_enable_ch1));
                    check_field("fire_enable_ch2", 32'(want.fire_enable_ch2),
                                32'(rep_word.fire_enable_ch2));
                    check_field("firing", 32'(want.firing), 32'(rep_word.firing));
                    check_field("reading_valid", 32'(want.reading_valid),
                                32'(rep_word.reading_valid));
                    check_field("raw_ch1", 32'(want.raw_ch1), 32'(rep_word.raw_ch1));
                    check_field("status_ch1", 32'(want.status_ch1),
                                32'(rep_word.status_ch1));
                    check_field("raw_ch2", 32'(want.raw_ch2), 32'(rep_word.raw_ch2));
                    check_field("status_ch2", 32'(want.status_ch2),
                                32'(rep_word.status_ch2));
                end
                seen++;
            end
            if (cmd_valid && cmd_ready)
            begin
                advance(cmd_word, fresh);
                reports_due.push_back(fresh);
            end
            waiting <= reports_due.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// top of the sequencer test: clock, reset, register writes and command words
// with random idling on both channels; the report checker gives the verdict count
// depends on pcs_pkg, pcs_cmd_if, pcs_report_if, the sequencer and pcs_report_checker
module testbench;
    import pcs_pkg::*;

    localparam int         LIMIT  = 200000;
    localparam int         CHUNK  = 105;
    localparam logic [1:0] CH_BAD = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending;
    int errors;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;

    logic [ADC_W-1:0] open_th = RST_OPEN_THRESHOLD;
    logic [ADC_W-1:0] short_th = RST_SHORT_THRESHOLD;

    pcs_cmd_if    cmd_ch ();
    pcs_report_if rep_ch ();

    pyro_channel_sequencer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .report  (rep_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pcs_report_checker report_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_ch.valid),
        .cmd_ready (cmd_ch.ready),
        .cmd_word  (cmd_ch.payload),
        .rep_valid (rep_ch.valid),
        .rep_ready (rep_ch.ready),
        .rep_word  (rep_ch.payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rep_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("[pyro_channel_sequencer_unit] ERROR");
            $finish;
        end
    end

    task automatic push_word(input cmd_word_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= w;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic tick(input logic [TIME_W-1:0] now, input logic [ADC_W-1:0] a1,
                        input logic [ADC_W-1:0] a2);
        cmd_word_t w;
        w.req_type = REQ_TICK;
        w.channel  = 2'($urandom_range(0, 3));
        w.now_ms   = now;
        w.adc_ch1  = a1;
        w.adc_ch2  = a2;
        push_word(w);
    endtask

    task automatic fire(input logic [1:0] ch, input logic [TIME_W-1:0] now);
        cmd_word_t w;
        w.req_type = REQ_FIRE;
        w.channel  = ch;
        w.now_ms   = now;
        w.adc_ch1  = 12'($urandom_range(0, 4095));
        w.adc_ch2  = 12'($urandom_range(0, 4095));
        push_word(w);
    endtask

    // random half the time, right around a threshold the other half
    function automatic logic [ADC_W-1:0] sample_adc();
        logic [ADC_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 12'(open_th + $urandom_range(0, 2) - 1);
            1: v = 12'(short_th + $urandom_range(0, 2) - 1);
            default: v = 12'($urandom_range(0, 4095));
        endcase
        return v;
    endfunction

    // stop sending and wait until every report has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // psel stays high between back-to-back writes; the caller closes the burst
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input logic [DUR_W-1:0] settle, input logic [DUR_W-1:0] idle,
                                  input logic [DUR_W-1:0] pulse,
                                  input logic [ADC_W-1:0] open_v,
                                  input logic [ADC_W-1:0] short_v,
                                  input logic o1, input logic o2);
        drain();
        write_reg(REG_SETTLE_TIME, {16'b0, settle});
        write_reg(REG_IDLE_TIME, {16'b0, idle});
        write_reg(REG_FIRE_TIME, {16'b0, pulse});
        write_reg(REG_OPEN_THRESHOLD, {20'b0, open_v});
        write_reg(REG_SHORT_THRESHOLD, {20'b0, short_v});
        write_reg(REG_OWNS_CH1, {31'b0, o1});
        write_reg(REG_OWNS_CH2, {31'b0, o2});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        open_th  = open_v;
        short_th = short_v;
        @(posedge clk);
    endtask

    // mostly well-paced ticks with fire requests, plus stray times and bad channels
    task automatic run_chunk(input int count);
        logic [TIME_W-1:0] t;
        int                k;
        int                r;
        if ($urandom_range(0, 3) == 0)
        begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 300);
        end
        else
        begin
            t = $urandom;
        end
        for (k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                fire($urandom_range(0, 1) ? CH_TWO : CH_ONE, t);
            end
            else if (r < 15)
            begin
                fire($urandom_range(0, 1) ? CH_BAD : CH_NONE, t);
            end
            else if (r < 16)
            begin
                tick(t + $urandom, sample_adc(), sample_adc());
            end
            else if (r < 18)
            begin
                tick(t - $urandom_range(1, 32'h7FFF_FFFF), sample_adc(), sample_adc());
            end
            else
            begin
                t = t + $urandom_range(0, 8);
                tick(t, sample_adc(), sample_adc());
            end
        end
    endtask

    initial
    begin
        int mode;
        int s;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first reading, pulse, replaced pulse, threshold edges
        send_idle = 31;
        recv_idle = 61;
        tick(32'd0, 12'hFFF, 12'h000);
        tick(32'd9, 12'h123, 12'h456);
        tick(32'd10, 12'hFFF, 12'h000);
        fire(CH_ONE, 32'd20);
        fire(CH_NONE, 32'd21);
        fire(CH_BAD, 32'd22);
        tick(32'd519, 12'hAAA, 12'h555);
        fire(CH_TWO, 32'd519);
        tick(32'd1019, 12'h555, 12'hAAA);
        tick(32'd1029, 12'd50, 12'd3800);
        tick(32'd2018, 12'd0, 12'd0);
        tick(32'd2019, 12'd49, 12'd3801);
        tick(32'd2029, 12'd49, 12'd3801);

        // zero times, crossed thresholds, released channels, time wrap
        apply_settings(16'd0, 16'd0, 16'd0, 12'd0, 12'hFFF, 1'b0, 1'b0);
        fire(CH_ONE, 32'hFFFF_FFF0);
        tick(32'hFFFF_FFF0, 12'd0, 12'd1);
        fire(CH_TWO, 32'd5);
        tick(32'd5, 12'd7, 12'd9);
        tick(32'd6, 12'd0, 12'd1);
        fire(CH_ONE, 32'd7);
        fire(CH_TWO, 32'd8);
        tick(32'd8, 12'hFFF, 12'h800);

        // largest times and widest thresholds
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'd0, 1'b1, 1'b1);
        fire(CH_ONE, 32'h7FFF_FFFF);
        tick(32'h8000_FFFE, 12'd1, 12'd2);
        tick(32'h8001_FFFC, 12'hFFF, 12'hFFF);
        tick(32'h8001_FFFD, 12'hFFF, 12'd0);

        for (mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 31 : (mode == 1) ? 61 : 0;
            recv_idle = (mode == 0) ? 61 : (mode == 1) ? 31 : 0;
            for (s = 0; s < 4; s++)
            begin
                if (s == 3)
                begin
                    apply_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 30)), 12'($urandom_range(0, 4095)),
                                   12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
                else
                begin
                    apply_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 30)),
                                   12'($urandom_range(2048, 4095)),
                                   12'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
                run_chunk(CHUNK);
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[pyro_channel_sequencer_unit] OK");
        end
        else
        begin
            $display("[pyro_channel_sequencer_unit] ERROR");
        end
        $finish;
    end

endmodule
